FILE: design/delta_list_timer_queue_core_defines.svh
// Assertion macros shared by the timer queue RTL.
// No dependencies; the asserting module must have clk_i and rst_ni in scope.
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define DLTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define DLTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dltq_pkg.sv
// Shared types and codes of the delta-list timer queue.
// No dependencies; used by the ALU, output stage and top level.
`default_nettype none

package dltq_pkg;

  localparam int unsigned TASK_W = 4;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned KIND_W = 3;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    K_INSERTED = 3'd0,
    K_EXPIRED  = 3'd1,
    K_REMOVED  = 3'd2,
    K_NOEXP    = 3'd3,
    K_ERROR    = 3'd4
  } kind_e;

  // shared adder function
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // one result item
  typedef struct packed {
    kind_e             kind;
    logic [TASK_W-1:0] task_id;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

FILE: design/dltq_alu.sv
// Shared add/subtract unit with a compare against a limit.
// Depends on dltq_pkg for the function code.
`default_nettype none

module dltq_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  dltq_pkg::alu_op_e op_i,
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  input  logic [WIDTH-1:0]  c_i,
  output logic [WIDTH-1:0]  res_o,
  output logic              le_o
);

  logic             sub;
  logic [WIDTH-1:0] b_op;
  logic [WIDTH:0]   sum;

  // one adder; subtract by two's complement
  assign sub   = (op_i == dltq_pkg::ALU_SUB);
  assign b_op  = sub ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};
  assign res_o = sum[WIDTH-1:0];

  // unwrapped sum against the limit (meaningful for add)
  assign le_o  = (sum <= {1'b0, c_i});

endmodule

`default_nettype wire

FILE: design/dltq_mem.sv
// Slot store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module dltq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/dltq_out.sv
// Output register of the result stream; frees the sequencer from the sink.
// Depends on dltq_pkg for the result struct.
`default_nettype none

module dltq_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  dltq_pkg::res_t                res_i,
  output logic                          free_o,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [dltq_pkg::KIND_W-1:0]   kind_o,
  output logic [dltq_pkg::TASK_W-1:0]   task_id_o,
  output logic                          last_o
);

  logic           valid_q;
  dltq_pkg::res_t res_q;

  // room when empty or draining this cycle
  assign free_o = !valid_q || tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o  = valid_q;
  assign kind_o    = res_q.kind;
  assign task_id_o = res_q.task_id;
  assign last_o    = res_q.last;

endmodule

`default_nettype wire

FILE: design/delta_list_timer_queue_core.sv
// Delta-list timer queue. Timers sit in expiry order in a slot memory with one read and one
// write port, each holding a task id and its delay relative to the slot before it. A request
// is taken only while the sequencer is idle and runs through the read port of the slot
// memory and one shared adder: an insert or remove first scans all occupied slots, an
// insert then computes the delta of the new slot in S_ND, the slots behind the change shift
// by one place in S_MOVE, and the request finishes through S_MVEND and S_DONE. A tick
// decrements a nonzero head and, for each expiring timer, shifts the slots behind it down by
// one place to close the gap at the head. Results leave through an output register, so the
// next request is taken while the last result still waits on m_axis; a full output register
// holds the sequencer until the sink takes its item.
`default_nettype none

module delta_list_timer_queue_core #(
  parameter int unsigned NUM_TASKS  = 16,
  parameter int unsigned DELAY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] task_id, [35:4] delay, [39:36] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] task_id_res, [7:4] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last result of the request
);

  `include "delta_list_timer_queue_core_defines.svh"

  localparam int unsigned IDX_W  = $clog2(NUM_TASKS);
  localparam int unsigned CNT_W  = $clog2(NUM_TASKS + 1);
  localparam int unsigned TASK_W = dltq_pkg::TASK_W;
  localparam int unsigned ENT_W  = TASK_W + DELAY_BITS;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SCAN      = 10'b00_0000_0010,
    S_ND        = 10'b00_0000_0100,
    S_MOVE      = 10'b00_0000_1000,
    S_MVEND     = 10'b00_0001_0000,
    S_TICK_RD   = 10'b00_0010_0000,
    S_TICK_EV   = 10'b00_0100_0000,
    S_TICK_PEND = 10'b00_1000_0000,
    S_DONE      = 10'b01_0000_0000,
    S_SPARE     = 10'b10_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  // read pipeline shared by scan and move
  logic                  pv_q, pv_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      left_q, left_d;
  logic [IDX_W-1:0]      src_q, src_d;
  logic                  up_q, up_d;
  logic [IDX_W-1:0]      edge_q, edge_d;
  logic [DELAY_BITS-1:0] adj_q, adj_d;
  // scan results
  logic [DELAY_BITS-1:0] accu_q, accu_d;
  logic [CNT_W-1:0]      p_q, p_d;
  logic                  stop_q, stop_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      s_q, s_d;
  logic [DELAY_BITS-1:0] dels_q, dels_d;
  // request
  dltq_pkg::op_e         op_q, op_d;
  logic [TASK_W-1:0]     id_q, id_d;
  logic [DELAY_BITS-1:0] d_q, d_d;
  // tick bookkeeping
  logic                  first_q, first_d;
  logic                  pend_q, pend_d;
  logic [TASK_W-1:0]     pend_id_q, pend_id_d;
  logic [TASK_W-1:0]     hid_q, hid_d;
  // final result
  dltq_pkg::kind_e       res_kind_q, res_kind_d;
  logic [TASK_W-1:0]     res_id_q, res_id_d;

  logic                  in_acc;
  dltq_pkg::op_e         op_in;
  logic [63:0]           din_wide;
  logic [DELAY_BITS-1:0] din;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENT_W-1:0]      mem_rdata;
  logic [TASK_W-1:0]     rd_task;
  logic [DELAY_BITS-1:0] rd_delta;

  dltq_pkg::alu_op_e     alu_op;
  logic [DELAY_BITS-1:0] alu_a, alu_b, alu_res;
  logic                  alu_le;

  logic                  res_push;
  dltq_pkg::res_t        res_out;
  logic                  out_free;

  logic                  start_pop;
  logic [TASK_W-1:0]     pop_id;

  // request decode; delay masked to DELAY_BITS, zero clamped to one
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op_in         = dltq_pkg::op_e'(s_axis_tuser);
  assign din_wide      = 64'(s_axis_tdata[35:4]);
  assign din           = (din_wide[DELAY_BITS-1:0] == '0) ? DELAY_BITS'(1)
                                                           : din_wide[DELAY_BITS-1:0];

  assign rd_task  = mem_rdata[ENT_W-1 -: TASK_W];
  assign rd_delta = mem_rdata[DELAY_BITS-1:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    pv_d       = 1'b0;
    ptr_d      = ptr_q;
    left_d     = left_q;
    src_d      = src_q;
    up_d       = up_q;
    edge_d     = edge_q;
    adj_d      = adj_q;
    accu_d     = accu_q;
    p_d        = p_q;
    stop_d     = stop_q;
    found_d    = found_q;
    s_d        = s_q;
    dels_d     = dels_q;
    op_d       = op_q;
    id_d       = id_q;
    d_d        = d_q;
    first_d    = first_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    hid_d      = hid_q;
    res_kind_d = res_kind_q;
    res_id_d   = res_id_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = ptr_q;
    alu_op     = dltq_pkg::ALU_ADD;
    alu_a      = accu_q;
    alu_b      = rd_delta;
    res_push   = 1'b0;
    res_out    = '{kind: res_kind_q, task_id: res_id_q, last: 1'b1};
    start_pop  = 1'b0;
    pop_id     = hid_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = op_in;
          id_d    = s_axis_tdata[TASK_W-1:0];
          d_d     = din;
          accu_d  = '0;
          p_d     = '0;
          stop_d  = 1'b0;
          found_d = 1'b0;
          ptr_d   = '0;
          left_d  = occ_q;
          up_d    = 1'b0;
          first_d = 1'b1;
          pend_d  = 1'b0;
          unique case (op_in)
            dltq_pkg::OP_INSERT: begin
              if (occ_q >= CNT_W'(NUM_TASKS)) begin
                res_kind_d = dltq_pkg::K_ERROR;
                res_id_d   = s_axis_tdata[TASK_W-1:0];
                state_d    = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            dltq_pkg::OP_TICK: begin
              if (occ_q == '0) begin
                res_kind_d = dltq_pkg::K_NOEXP;
                res_id_d   = '0;
                state_d    = S_DONE;
              end else begin
                state_d = S_TICK_RD;
              end
            end
            dltq_pkg::OP_REMOVE: begin
              state_d = S_SCAN;
            end
            dltq_pkg::OP_BAD: begin
              res_kind_d = dltq_pkg::K_ERROR;
              res_id_d   = s_axis_tdata[TASK_W-1:0];
              state_d    = S_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // issue next read
        if (left_q != '0) begin
          ptr_d  = ptr_q + 1'b1;
          left_d = left_q - 1'b1;
          pv_d   = 1'b1;
          src_d  = ptr_q;
        end
        // walk position and id match on returned slot
        if (pv_q) begin
          if (!stop_q) begin
            if (alu_le) begin
              accu_d = alu_res;
              p_d    = p_q + 1'b1;
            end else begin
              stop_d = 1'b1;
            end
          end
          if ((rd_task == id_q) && !found_q) begin
            found_d = 1'b1;
            s_d     = src_q;
            dels_d  = rd_delta;
          end
        end
        if ((left_q == '0) && !pv_q) begin
          if (op_q == dltq_pkg::OP_INSERT) begin
            if (found_q) begin
              res_kind_d = dltq_pkg::K_ERROR;
              res_id_d   = id_q;
              state_d    = S_DONE;
            end else begin
              state_d = S_ND;
            end
          end else if (!found_q) begin
            res_kind_d = dltq_pkg::K_ERROR;
            res_id_d   = id_q;
            state_d    = S_DONE;
          end else begin
            // close the gap behind the removed slot
            ptr_d   = s_q + 1'b1;
            left_d  = occ_q - CNT_W'(s_q) - 1'b1;
            edge_d  = s_q + 1'b1;
            adj_d   = dels_q;
            up_d    = 1'b0;
            state_d = S_MOVE;
          end
        end
      end

      S_ND: begin
        // delta of the new slot, then open a gap at its place
        alu_op  = dltq_pkg::ALU_SUB;
        alu_a   = d_q;
        alu_b   = accu_q;
        adj_d   = alu_res;
        ptr_d   = IDX_W'(occ_q - 1'b1);
        left_d  = occ_q - p_q;
        edge_d  = p_q[IDX_W-1:0];
        up_d    = 1'b1;
        state_d = S_MOVE;
      end

      S_MOVE: begin
        if (left_q != '0) begin
          ptr_d  = up_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
          left_d = left_q - 1'b1;
          pv_d   = 1'b1;
          src_d  = ptr_q;
        end
        // write the slot one place over; adjust the slot at the edge
        if (pv_q) begin
          alu_op    = up_q ? dltq_pkg::ALU_SUB : dltq_pkg::ALU_ADD;
          alu_a     = rd_delta;
          alu_b     = adj_q;
          mem_we    = 1'b1;
          mem_waddr = up_q ? src_q + 1'b1 : src_q - 1'b1;
          mem_wdata = {rd_task, (src_q == edge_q) ? alu_res : rd_delta};
        end
        if ((left_q == '0) && !pv_q) begin
          state_d = S_MVEND;
        end
      end

      S_MVEND: begin
        unique case (op_q)
          dltq_pkg::OP_INSERT: begin
            mem_we     = 1'b1;
            mem_waddr  = p_q[IDX_W-1:0];
            mem_wdata  = {id_q, adj_q};
            occ_d      = occ_q + 1'b1;
            res_kind_d = dltq_pkg::K_INSERTED;
            res_id_d   = id_q;
            state_d    = S_DONE;
          end
          dltq_pkg::OP_REMOVE: begin
            occ_d      = occ_q - 1'b1;
            res_kind_d = dltq_pkg::K_REMOVED;
            res_id_d   = id_q;
            state_d    = S_DONE;
          end
          dltq_pkg::OP_TICK: begin
            occ_d = occ_q - 1'b1;
            if (occ_q == CNT_W'(1)) begin
              res_kind_d = dltq_pkg::K_EXPIRED;
              res_id_d   = pend_id_q;
              state_d    = S_DONE;
            end else begin
              state_d = S_TICK_RD;
            end
          end
          dltq_pkg::OP_BAD: begin
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_TICK_RD: begin
        mem_raddr = '0;
        state_d   = S_TICK_EV;
      end

      S_TICK_EV: begin
        // first pass decrements a nonzero head
        alu_op    = dltq_pkg::ALU_SUB;
        alu_a     = rd_delta;
        alu_b     = {{(DELAY_BITS-1){1'b0}}, first_q && (rd_delta != '0)};
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {rd_task, alu_res};
        first_d   = 1'b0;
        hid_d     = rd_task;
        if (alu_res != '0) begin
          res_kind_d = pend_q ? dltq_pkg::K_EXPIRED : dltq_pkg::K_NOEXP;
          res_id_d   = pend_q ? pend_id_q : '0;
          state_d    = S_DONE;
        end else if (pend_q) begin
          state_d = S_TICK_PEND;
        end else begin
          start_pop = 1'b1;
          pop_id    = rd_task;
        end
      end

      S_TICK_PEND: begin
        // earlier expiry is not the last one
        if (out_free) begin
          res_push  = 1'b1;
          res_out   = '{kind: dltq_pkg::K_EXPIRED, task_id: pend_id_q, last: 1'b0};
          start_pop = 1'b1;
          pop_id    = hid_q;
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_push = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_SPARE: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // drop the expired head: shift slots down by one
    if (start_pop) begin
      ptr_d     = IDX_W'(1);
      left_d    = occ_q - 1'b1;
      edge_d    = IDX_W'(1);
      adj_d     = '0;
      up_d      = 1'b0;
      pend_d    = 1'b1;
      pend_id_d = pop_id;
      state_d   = S_MOVE;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      pv_q    <= pv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    left_q     <= left_d;
    src_q      <= src_d;
    up_q       <= up_d;
    edge_q     <= edge_d;
    adj_q      <= adj_d;
    accu_q     <= accu_d;
    p_q        <= p_d;
    stop_q     <= stop_d;
    found_q    <= found_d;
    s_q        <= s_d;
    dels_q     <= dels_d;
    op_q       <= op_d;
    id_q       <= id_d;
    d_q        <= d_d;
    first_q    <= first_d;
    pend_q     <= pend_d;
    pend_id_q  <= pend_id_d;
    hid_q      <= hid_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
  end

  dltq_alu #(
    .WIDTH(DELAY_BITS)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .c_i  (d_q),
    .res_o(alu_res),
    .le_o (alu_le)
  );

  dltq_mem #(
    .DEPTH(NUM_TASKS),
    .WIDTH(ENT_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  logic [TASK_W-1:0] out_id;

  dltq_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res_push),
    .res_i    (res_out),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .kind_o   (m_axis_tuser),
    .task_id_o(out_id),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(8-TASK_W){1'b0}}, out_id};

  // checks
  `DLTQ_ASSERT(a_occ_bound, occ_q <= CNT_W'(NUM_TASKS), "occupancy above capacity")
  `DLTQ_ASSERT(a_wr_range, mem_we |-> (CNT_W'(mem_waddr) <= occ_q), "slot write past tail")
  `DLTQ_ASSERT(a_push_free, res_push |-> out_free, "result pushed into full output register")
  `DLTQ_ASSERT(a_found_idx, (found_q && (state_q == S_SCAN)) |-> (CNT_W'(s_q) < occ_q), "matched slot beyond tail")
  `DLTQ_ASSERT_NEXT(a_ins_grow, (state_q == S_MVEND) && (op_q == dltq_pkg::OP_INSERT), occ_q == $past(occ_q) + 1'b1, "insert did not grow queue")

endmodule

`default_nettype wire
